// ----- rtl/ewh_pkg.sv -----
// shared types, constants and sequencer states of the equal-width histogram
package ewh_pkg;

    // value and bound width
    localparam int VALUE_BITS   = 32;
    // default bucket storage depth
    localparam int BUCKETS_DEF  = 64;
    // width of the bucket_number register
    localparam int NUM_BITS     = 7;
    // counter widths of one bucket row
    localparam int SUM_BITS     = 48;
    localparam int DIST_BITS    = 32;
    localparam int ROW_BITS     = SUM_BITS + DIST_BITS;
    // configuration port address width
    localparam int PADDR_BITS   = 4;

    // commands
    localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
    localparam logic [1:0] CMD_LOOKUP     = 2'd1;
    localparam logic [1:0] CMD_READ       = 2'd2;

    // register indexes (word address)
    localparam logic [1:0] REG_LOW     = 2'd0;
    localparam logic [1:0] REG_HIGH    = 2'd1;
    localparam logic [1:0] REG_BUCKETS = 2'd2;

    // reset values of the registers
    localparam logic [VALUE_BITS-1:0] LOW_RESET  = VALUE_BITS'(0);
    localparam logic [VALUE_BITS-1:0] HIGH_RESET = VALUE_BITS'(63);
    localparam logic [NUM_BITS-1:0]   NUM_RESET  = NUM_BITS'(64);

    // command beat
    typedef struct packed {
        logic [1:0]                   command;
        logic signed [VALUE_BITS-1:0] value;
        logic [31:0]                  weight;
        logic [5:0]                   bucket_index;
    } item_t;

    // result beat
    typedef struct packed {
        logic [5:0]                   bucket_found;
        logic                         in_range;
        logic [SUM_BITS-1:0]          row_total;
        logic [DIST_BITS-1:0]         distinct_total;
        logic signed [VALUE_BITS-1:0] bucket_low;
        logic signed [VALUE_BITS-1:0] bucket_high;
    } result_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_WIDE,
        ST_CHECK,
        ST_LOCATE,
        ST_DIV,
        ST_FETCH,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/ewh_ram.sv -----
// generic simple dual-port ram with registered read
module ewh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ewh_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module ewh_div #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH:0]   divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH:0]   remainder
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH:0]   rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH:0]   div_reg;
    logic [WIDTH:0]   trial;
    logic             fits;

    // one restoring step
    assign trial = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
    assign fits  = (trial >= div_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - div_reg) : trial;
            quo_reg <= {quo_reg[WIDTH-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // checks
    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still iterating");

    a_start_runs : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("divider did not start");

    a_rem_below : assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && div_reg != '0) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

endmodule

// ----- rtl/equal_width_histogram.sv -----
// equal-width histogram: top level with config port, sequencer and data path
//
// Commands enter on item when start is high and busy is low. Each command gives
// exactly one result beat on result, marked by a single-cycle done strobe; the
// receiver has no way to stall it, so it must take the beat in that cycle.
// Accumulate and lookup pass from acceptance to done through a check step, a
// locate step, the shared bit-serial divider (value offset by bucket width)
// and the counter memory fetch and update. A bucket read skips locate and the
// divider; an out-of-range value or unknown command ends at the check. One
// command is in flight at a time, so the next one can be accepted in the cycle
// done is shown. After reset the block sweeps the counter memory to zero, one
// row a cycle, then divides the span by the bucket count; busy stays high
// meanwhile. Every config write repeats that division, so busy goes high after
// it. Counters are not cleared by config writes. Registers sit on the APB
// port: low_bound at 0x0, high_bound at 0x4, bucket_number at 0x8.
module equal_width_histogram #(
    parameter int BUCKETS = ewh_pkg::BUCKETS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ewh_pkg::item_t                      item,
    output logic                                done,
    output ewh_pkg::result_t                    result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ewh_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    import ewh_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    // configuration registers
    logic [VB-1:0]       low_reg;
    logic [VB-1:0]       high_reg;
    logic [NUM_BITS-1:0] bnum_reg;
    logic                dirty_reg;
    logic                cfg_write;

    // cached geometry
    logic [VB-1:0]       base_reg;
    logic [NUM_BITS-1:0] extra_reg;
    logic [VB-1:0]       wide_reg;

    // sequencer and command context
    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    clr_reg;
    logic [1:0]          cmd_reg;
    logic [VB-1:0]       value_reg;
    logic [31:0]         weight_reg;
    logic [5:0]          index_reg;
    logic [VB-1:0]       d_reg;
    logic                sel_wide_reg;
    logic [NUM_BITS-1:0] idx_reg;
    logic [VB-1:0]       lo_reg;
    result_t             res_reg;
    result_t             res_next;
    logic                done_reg;
    logic                emit;

    // geometry from the registers
    logic [NUM_BITS-1:0] n_cur;
    logic                valid_cur;
    logic [VB-1:0]       span;

    // check cycle decisions
    logic                out_of_range;
    logic                chk_empty;
    logic                chk_read_bad;

    // divider
    logic                div_start;
    logic [VB-1:0]       div_dividend;
    logic [VB:0]         div_divisor;
    logic                div_done;
    logic [VB-1:0]       div_quo;
    logic [VB:0]         div_rem;
    logic [VB:0]         idx_full;
    logic [NUM_BITS-1:0] idx_clamped;

    // bucket bounds
    logic [VB-1:0]       prod;
    logic [NUM_BITS-1:0] min_ie;
    logic [VB-1:0]       lo_cur;
    logic [VB-1:0]       hi_cur;
    logic                last_bucket;
    logic [VB:0]         wide_full;

    // counter memory
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ROW_BITS-1:0] ram_rdata;
    logic [SUM_BITS-1:0] ws_old;
    logic [DIST_BITS-1:0] ds_old;
    logic [SUM_BITS:0]   ws_sum;
    logic [SUM_BITS-1:0] ws_new;
    logic [DIST_BITS-1:0] ds_new;

    // config port
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= LOW_RESET;
            high_reg <= HIGH_RESET;
            bnum_reg <= NUM_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_LOW:     low_reg  <= pwdata[VB-1:0];
                REG_HIGH:    high_reg <= pwdata[VB-1:0];
                REG_BUCKETS: bnum_reg <= pwdata[NUM_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_LOW:     prdata = low_reg;
            REG_HIGH:    prdata = high_reg;
            REG_BUCKETS: prdata = {{(32 - NUM_BITS){1'b0}}, bnum_reg};
            default:     prdata = '0;
        endcase
    end

    // bucket count in use, span and bound order
    always_comb
    begin
        if (bnum_reg == '0)
            n_cur = NUM_BITS'(1);
        else if (int'(bnum_reg) > BUCKETS)
            n_cur = NUM_BITS'(BUCKETS);
        else
            n_cur = bnum_reg;
    end

    assign span      = high_reg - low_reg + VB'(1);
    assign valid_cur = ($signed(high_reg) >= $signed(low_reg));

    // check cycle decisions
    assign out_of_range = !valid_cur || ($signed(value_reg) < $signed(low_reg))
                          || ($signed(value_reg) > $signed(high_reg));
    assign chk_read_bad = !valid_cur || ({1'b0, index_reg} >= n_cur);
    assign chk_empty    = (cmd_reg == CMD_READ) ? chk_read_bad
                        : ((cmd_reg == CMD_ACCUMULATE) || (cmd_reg == CMD_LOOKUP))
                          ? out_of_range : 1'b1;

    // bucket index from the quotient, clamped to the last bucket
    assign idx_full = sel_wide_reg ? {1'b0, div_quo}
                    : ({1'b0, div_quo} + {{(VB + 1 - NUM_BITS){1'b0}}, extra_reg});
    assign idx_clamped = (idx_full >= {{(VB + 1 - NUM_BITS){1'b0}}, n_cur})
                       ? (n_cur - 1'b1) : idx_full[NUM_BITS-1:0];

    // bucket start: low + i * base + min(i, extra)
    assign prod   = VB'({{(VB - NUM_BITS){1'b0}}, idx_reg} * base_reg);
    assign min_ie = (idx_reg < extra_reg) ? idx_reg : extra_reg;
    assign lo_cur = low_reg + prod + {{(VB - NUM_BITS){1'b0}}, min_ie};

    // bucket end from its start
    assign last_bucket = ({1'b0, idx_reg} + 1'b1) >= {1'b0, n_cur};
    assign hi_cur = last_bucket ? high_reg
                  : (lo_reg + base_reg + {{(VB - 1){1'b0}}, (idx_reg < extra_reg)}
                     - VB'(1));

    // width covered by the wider buckets
    assign wide_full = ({{(VB + 1 - NUM_BITS){1'b0}}, extra_reg}
                       * ({1'b0, base_reg} + 1'b1));

    // saturating counter update
    assign ws_old = ram_rdata[ROW_BITS-1:DIST_BITS];
    assign ds_old = ram_rdata[DIST_BITS-1:0];
    assign ws_sum = {1'b0, ws_old} + {{(SUM_BITS + 1 - 32){1'b0}}, weight_reg};
    assign ws_new = ws_sum[SUM_BITS] ? {SUM_BITS{1'b1}} : ws_sum[SUM_BITS-1:0];
    assign ds_new = (ds_old == {DIST_BITS{1'b1}}) ? ds_old : (ds_old + 1'b1);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(BUCKETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (dirty_reg)
                    state_next = ST_PREP;
                else if (start)
                    state_next = ST_CHECK;
            end
            ST_PREP:
            begin
                if (div_done)
                    state_next = ST_WIDE;
            end
            ST_WIDE:
                state_next = ST_IDLE;
            ST_CHECK:
            begin
                if (chk_empty)
                    state_next = ST_IDLE;
                else if (cmd_reg == CMD_READ)
                    state_next = ST_FETCH;
                else
                    state_next = ST_LOCATE;
            end
            ST_LOCATE:
            begin
                if ((d_reg < wide_reg) || (base_reg != '0))
                    state_next = ST_DIV;
                else
                    state_next = ST_FETCH;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
                state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = span;
        div_divisor  = {{(VB + 1 - NUM_BITS){1'b0}}, n_cur};
        ram_we       = 1'b0;
        ram_waddr    = clr_reg;
        ram_wdata    = '0;
        ram_raddr    = IDX_W'(idx_reg);
        emit         = 1'b0;
        res_next     = '0;
        case (state_reg)
            ST_CLEAR:
                ram_we = 1'b1;
            ST_IDLE:
                div_start = dirty_reg;
            ST_CHECK:
            begin
                if (chk_empty)
                begin
                    emit = 1'b1;
                    if (cmd_reg == CMD_READ)
                        res_next.bucket_found = index_reg;
                end
            end
            ST_LOCATE:
            begin
                if (d_reg < wide_reg)
                begin
                    div_start    = 1'b1;
                    div_dividend = d_reg;
                    div_divisor  = {1'b0, base_reg} + 1'b1;
                end
                else if (base_reg != '0)
                begin
                    div_start    = 1'b1;
                    div_dividend = d_reg - wide_reg;
                    div_divisor  = {1'b0, base_reg};
                end
            end
            ST_FINISH:
            begin
                emit                    = 1'b1;
                res_next.bucket_found   = idx_reg[5:0];
                res_next.in_range       = 1'b1;
                res_next.bucket_low     = lo_reg;
                res_next.bucket_high    = hi_cur;
                res_next.row_total      = ws_old;
                res_next.distinct_total = ds_old;
                if (cmd_reg == CMD_ACCUMULATE)
                begin
                    ram_we                  = 1'b1;
                    ram_waddr               = IDX_W'(idx_reg);
                    ram_wdata               = {ws_new, ds_new};
                    res_next.row_total      = ws_new;
                    res_next.distinct_total = ds_new;
                end
            end
            default:
                ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg <= 1'b1;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
            if (cfg_write)
                dirty_reg <= 1'b1;
            else if (state_reg == ST_IDLE && dirty_reg)
                dirty_reg <= 1'b0;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= res_next;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg    <= item.command;
                value_reg  <= item.value;
                weight_reg <= item.weight;
                index_reg  <= item.bucket_index;
            end
            ST_PREP:
            begin
                if (div_done)
                begin
                    base_reg  <= div_quo;
                    extra_reg <= div_rem[NUM_BITS-1:0];
                end
            end
            ST_WIDE:
                wide_reg <= wide_full[VB-1:0];
            ST_CHECK:
            begin
                d_reg   <= value_reg - low_reg;
                idx_reg <= {1'b0, index_reg};
            end
            ST_LOCATE:
            begin
                sel_wide_reg <= (d_reg < wide_reg);
                idx_reg      <= n_cur - 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                    idx_reg <= idx_clamped;
            end
            ST_FETCH:
                lo_reg <= lo_cur;
            default:
                ;
        endcase
    end

    // shared divider
    ewh_div #(
        .WIDTH (VB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // bucket counters
    ewh_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ST_IDLE) || dirty_reg;
    assign done   = done_reg;
    assign result = res_reg;

    // checks
    a_no_double_beat : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("two result beats in a row");

    a_accept_check : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_CHECK))
        else $error("accepted command not checked");

    a_idx_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (idx_reg < n_cur))
        else $error("bucket index beyond bucket count");

    a_div_owner : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_PREP || state_reg == ST_DIV))
        else $error("divider finished outside a divide step");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the equal-width histogram: command and apb drivers, scoreboard
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ewh_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN      = 2'd3;
    localparam int         CYCLE_LIMIT      = 500000;
    localparam int         PHASES           = 12;
    localparam int         RANDOM_PER_PHASE = 86;
    localparam int         TAIL_CYCLES      = 40;
    localparam int         IDLE_PCT [4]     = '{0, 49, 0, 25};

    // scoreboard: histogram predictor and queue of expected result beats
    class hist_scoreboard;
        bit [VALUE_BITS-1:0] cfg_low;
        bit [VALUE_BITS-1:0] cfg_high;
        bit [NUM_BITS-1:0]   cfg_count;
        bit [SUM_BITS-1:0]   row_weight [BUCKETS_DEF];
        bit [DIST_BITS-1:0]  row_distinct [BUCKETS_DEF];
        result_t             pending_results [$];
        int                  failures;

        function new();
            cfg_low   = LOW_RESET;
            cfg_high  = HIGH_RESET;
            cfg_count = NUM_RESET;
            failures  = 0;
        endfunction

        task report(string msg);
            failures++;
            if (failures <= 40)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        function void set_register(logic [1:0] index, logic [31:0] data);
            case (index)
                REG_LOW:     cfg_low   = data;
                REG_HIGH:    cfg_high  = data;
                REG_BUCKETS: cfg_count = data[NUM_BITS-1:0];
                default:     ;
            endcase
        endfunction

        // bucket count in force: zero acts as one, large values clip to the depth
        function longint unsigned live_buckets();
            if (cfg_count == 0)
                return 1;
            if (cfg_count > BUCKETS_DEF)
                return BUCKETS_DEF;
            return cfg_count;
        endfunction

        function longint unsigned bucket_first(longint unsigned i, longint unsigned base,
                                               longint unsigned extra);
            return cfg_low + i * base + ((i < extra) ? i : extra);
        endfunction

        // counts and bounds of one bucket
        function result_t bucket_row(longint unsigned idx, longint unsigned n,
                                     longint unsigned base, longint unsigned extra);
            result_t         r;
            longint unsigned lo;
            longint unsigned hi;
            lo = bucket_first(idx, base, extra);
            if (idx + 1 >= n)
                hi = cfg_high;
            else
                hi = bucket_first(idx + 1, base, extra) - 1;
            r.bucket_found   = idx[5:0];
            r.in_range       = 1'b1;
            r.row_total      = row_weight[idx];
            r.distinct_total = row_distinct[idx];
            r.bucket_low     = lo[31:0];
            r.bucket_high    = hi[31:0];
            return r;
        endfunction

        // work out the result of an accepted command and update the counters
        function void note_command(item_t it);
            result_t             r;
            longint              lo_s;
            longint              hi_s;
            longint              v;
            longint unsigned     n;
            longint unsigned     span;
            longint unsigned     base;
            longint unsigned     extra;
            longint unsigned     idx;
            longint unsigned     d;
            longint unsigned     wide;
            longint unsigned     sum;
            bit [VALUE_BITS-1:0] span32;
            bit [VALUE_BITS-1:0] d32;
            bit                  ordered;
            r       = '0;
            lo_s    = $signed(cfg_low);
            hi_s    = $signed(cfg_high);
            ordered = hi_s >= lo_s;
            n       = live_buckets();
            span32  = cfg_high - cfg_low + 32'd1;
            span    = span32;
            base    = span / n;
            extra   = span % n;
            v       = $signed(it.value);
            case (it.command)
                CMD_READ:
                begin
                    idx = it.bucket_index;
                    if (!ordered || idx >= n)
                        r.bucket_found = it.bucket_index;
                    else
                        r = bucket_row(idx, n, base, extra);
                end
                CMD_ACCUMULATE, CMD_LOOKUP:
                begin
                    if (ordered && v >= lo_s && v <= hi_s)
                    begin
                        d32  = it.value - cfg_low;
                        d    = d32;
                        wide = extra * (base + 1);
                        if (d < wide)
                            idx = d / (base + 1);
                        else if (base != 0)
                            idx = extra + (d - wide) / base;
                        else
                            idx = n - 1;
                        if (idx >= n)
                            idx = n - 1;
                        // accumulate saturates both counters
                        if (it.command == CMD_ACCUMULATE)
                        begin
                            sum = longint'(row_weight[idx]) + longint'(it.weight);
                            row_weight[idx] = (sum > 64'hFFFF_FFFF_FFFF) ? '1 : sum[47:0];
                            if (row_distinct[idx] != '1)
                                row_distinct[idx]++;
                        end
                        r = bucket_row(idx, n, base, extra);
                    end
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        // compare a result beat with the oldest expectation
        task check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result beat with no command pending: %h", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.bucket_found !== want.bucket_found)
                report($sformatf("bucket_found got %0d want %0d",
                                 got.bucket_found, want.bucket_found));
            if (got.in_range !== want.in_range)
                report($sformatf("in_range got %b want %b", got.in_range, want.in_range));
            if (got.row_total !== want.row_total)
                report($sformatf("row_total got %0h want %0h", got.row_total, want.row_total));
            if (got.distinct_total !== want.distinct_total)
                report($sformatf("distinct_total got %0h want %0h",
                                 got.distinct_total, want.distinct_total));
            if (got.bucket_low !== want.bucket_low)
                report($sformatf("bucket_low got %0d want %0d", got.bucket_low, want.bucket_low));
            if (got.bucket_high !== want.bucket_high)
                report($sformatf("bucket_high got %0d want %0d",
                                 got.bucket_high, want.bucket_high));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    hist_scoreboard sb = new();
    int             cycles = 0;

    equal_width_histogram u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("equal_width_histogram verification failed");
            $finish;
        end
    end

    // result beats are taken on the edge that ends their cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // random command aimed mostly at the configured range
    function automatic item_t make_command();
        item_t           it;
        longint          lo_s;
        longint          hi_s;
        longint unsigned span;
        longint unsigned n;
        int              pick;
        lo_s = $signed(sb.cfg_low);
        hi_s = $signed(sb.cfg_high);
        n    = sb.live_buckets();
        pick = $urandom_range(99);
        if (pick < 40)
            it.command = CMD_ACCUMULATE;
        else if (pick < 65)
            it.command = CMD_LOOKUP;
        else if (pick < 94)
            it.command = CMD_READ;
        else
            it.command = CMD_UNKNOWN;
        pick = $urandom_range(99);
        if (hi_s >= lo_s && pick < 70)
        begin
            span     = hi_s - lo_s + 1;
            it.value = lo_s + ({$urandom, $urandom} % span);
        end
        else if (pick < 85)
        begin
            case ($urandom_range(3))
                0:       it.value = lo_s - 1;
                1:       it.value = lo_s;
                2:       it.value = hi_s;
                default: it.value = hi_s + 1;
            endcase
        end
        else
            it.value = $urandom;
        pick = $urandom_range(99);
        if (pick < 10)
            it.weight = '0;
        else if (pick < 20)
            it.weight = '1;
        else if (pick < 50)
            it.weight = $urandom_range(15);
        else
            it.weight = $urandom;
        if ($urandom_range(99) < 75)
            it.bucket_index = $urandom_range(63);
        else
            it.bucket_index = $urandom_range(1) ? (n - 1) : n;
        return it;
    endfunction

    // sender idle for one cycle, with noise on the command bus
    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
        item  <= make_command();
    endtask

    // offer one command beat until the block takes it
    task automatic send(item_t it);
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(it);
    endtask

    task automatic issue(logic [1:0] c, logic [31:0] v, logic [31:0] w, logic [5:0] bi);
        item_t it;
        it.command      = c;
        it.value        = v;
        it.weight       = w;
        it.bucket_index = bi;
        send(it);
    endtask

    // stop sending and wait for every pending result
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // apb write: setup then access, then the span division restarts
    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(index, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        while (!busy)
            @(posedge clk);
    endtask

    task automatic configure(logic [31:0] low, logic [31:0] high, logic [6:0] count);
        settle();
        write_reg(REG_LOW, low);
        write_reg(REG_HIGH, high);
        write_reg(REG_BUCKETS, {25'd0, count});
    endtask

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        logic [6:0]  nb;
        int          pct;
        start   = 1'b0;
        item    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset range 0..63 over 64 buckets: zero and full weight, both range edges
        issue(CMD_ACCUMULATE, 32'd0, 32'd0, 6'd0);
        issue(CMD_ACCUMULATE, 32'd63, 32'hFFFF_FFFF, 6'd63);
        issue(CMD_ACCUMULATE, 32'hFFFF_FFFF, 32'd9, 6'd0);
        issue(CMD_ACCUMULATE, 32'd64, 32'd9, 6'd0);
        issue(CMD_LOOKUP, 32'h7FFF_FFFF, 32'd0, 6'd0);
        issue(CMD_LOOKUP, 32'h8000_0000, 32'd0, 6'd0);
        issue(CMD_LOOKUP, 32'd63, 32'd0, 6'd0);
        issue(CMD_READ, 32'd0, 32'd0, 6'd0);
        issue(CMD_READ, 32'd0, 32'd0, 6'd63);
        issue(CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);

        // inverted bounds
        configure(32'd10, 32'd5, 7'd7);
        issue(CMD_LOOKUP, 32'd7, 32'd0, 6'd0);
        issue(CMD_READ, 32'd0, 32'd0, 6'd0);

        // fewer values than buckets leaves empty buckets at the top
        configure(32'd0, 32'd4, 7'd8);
        issue(CMD_READ, 32'd0, 32'd0, 6'd6);
        issue(CMD_READ, 32'd0, 32'd0, 6'd7);
        issue(CMD_ACCUMULATE, 32'd4, 32'd5, 6'd0);
        issue(CMD_READ, 32'd0, 32'd0, 6'd8);

        // bucket count of zero
        configure(32'hFFFF_FFFB, 32'd20, 7'd0);
        issue(CMD_ACCUMULATE, 32'd20, 32'd3, 6'd0);
        issue(CMD_READ, 32'd0, 32'd0, 6'd0);

        // whole value range, bucket count above the depth
        configure(32'h8000_0000, 32'h7FFF_FFFF, 7'd127);
        issue(CMD_ACCUMULATE, 32'h8000_0000, 32'hFFFF_FFFF, 6'd0);
        issue(CMD_LOOKUP, 32'h7FFF_FFFF, 32'd0, 6'd0);
        issue(CMD_READ, 32'd0, 32'd0, 6'd0);
        issue(CMD_READ, 32'd0, 32'd0, 6'd63);

        // random phases over a spread of ranges and bucket counts
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lo = 32'd0;            hi = 32'd63;           nb = 7'd64;
                end
                1:
                begin
                    lo = 32'h8000_0000;    hi = 32'h7FFF_FFFF;    nb = 7'd64;
                end
                2:
                begin
                    lo = 32'h8000_0000;    hi = 32'h7FFF_FFFF;    nb = 7'd1;
                end
                3:
                begin
                    lo = 32'd100;          hi = 32'd100;          nb = 7'd1;
                end
                4:
                begin
                    lo = 32'hFFFF_FC18;    hi = 32'd1000;         nb = 7'd0;
                end
                5:
                begin
                    lo = 32'd5;            hi = 32'd1000;         nb = 7'd127;
                end
                6:
                begin
                    lo = 32'd0;            hi = 32'd9;            nb = 7'd64;
                end
                7:
                begin
                    lo = 32'd10;           hi = 32'd5;            nb = 7'd7;
                end
                8:
                begin
                    lo = 32'h7FFF_FFD7;    hi = 32'h7FFF_FFFF;    nb = 7'd33;
                end
                9:
                begin
                    lo = 32'h8000_0000;    hi = 32'h8000_00C8;    nb = 7'd63;
                end
                10:
                begin
                    lo = $urandom;
                    hi = lo + $urandom_range(0, 5000);
                    nb = $urandom_range(1, 64);
                end
                default:
                begin
                    lo = $urandom;
                    hi = $urandom;
                    nb = $urandom_range(0, 127);
                end
            endcase
            configure(lo, hi, nb);
            pct = IDLE_PCT[p % 4];
            repeat (RANDOM_PER_PHASE)
            begin
                if ($urandom_range(99) < pct)
                    repeat ($urandom_range(1, 45))
                        idle_cycle();
                send(make_command());
            end
        end

        // drain and let any stray beat show up
        settle();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("equal_width_histogram verification clean");
        else
            $display("equal_width_histogram verification failed");
        $finish;
    end

endmodule
